FILE: src/srtf_task_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// srtf_task_scheduler_top_macros.svh - assertion macros
// Shared shorthand for the concurrent checks of the scheduler.
// ----------------------------------------------------------------------------
`ifndef SRTF_TASK_SCHEDULER_TOP_MACROS_SVH
`define SRTF_TASK_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SRTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define SRTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg - scheduler package
// Widths, scan record, control bundle, result and state types.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int BURST_W        = 16;
    localparam int SEQ_W          = 16;
    localparam int TIME_W         = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // record that walks down the row of cells once per tick
    typedef struct packed {
        logic               valid;
        logic               arrive;      // arrival still looking for a slot
        logic               placed;      // arrival took a slot
        logic [BURST_W-1:0] burst;
        logic [SEQ_W-1:0]   seq;
        logic               best_ok;
        logic [BURST_W-1:0] best_rem;
        logic [TIME_W-1:0]  best_age;
        logic [SEQ_W-1:0]   best_seq;
        logic [BURST_W-1:0] best_burst;
        logic               last_ok;
        logic [BURST_W-1:0] last_rem;
        logic [TIME_W-1:0]  last_age;
        logic [SEQ_W-1:0]   last_seq;
        logic [BURST_W-1:0] last_burst;
    } t_scan;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              last_valid;
        logic              commit;
        logic              finish;
    } t_ctl;

    typedef struct packed {
        logic              ran_valid;
        logic [SEQ_W-1:0]  task_number;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              dropped;
    } t_result;

endpackage

FILE: src/srtf_if.sv
// ----------------------------------------------------------------------------
// srtf_if - scheduler channels
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface srtf_tick_if import srtf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               arrive_valid;
    logic [BURST_W-1:0] burst;

    modport source (output valid, output arrive_valid, output burst, input ready);
    modport sink   (input valid, input arrive_valid, input burst, output ready);
endinterface

interface srtf_result_if import srtf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ran_valid;
    logic [SEQ_W-1:0]  task_number;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              dropped;

    modport source (
        output valid, output ran_valid, output task_number, output finished,
        output completion_time, output turnaround, output waiting, output dropped,
        input ready
    );
    modport sink (
        input valid, input ran_valid, input task_number, input finished,
        input completion_time, input turnaround, input waiting, input dropped,
        output ready
    );
endinterface

FILE: src/srtf_cell.sv
// ----------------------------------------------------------------------------
// srtf_cell - one task slot
// Holds one task, claims a pending arrival when free, and folds itself into
// the scan record before handing it to the next cell.
// ----------------------------------------------------------------------------
module srtf_cell import srtf_pkg::*; #(
    parameter  int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter  int IDX        = 0,
    localparam int SW         = $clog2(TASK_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [SW-1:0] i_last_slot,
    input  logic [SW-1:0] i_pick_slot,
    input  t_scan         i_rec,
    input  logic [SW-1:0] i_best_slot,
    output t_scan         o_rec,
    output logic [SW-1:0] o_best_slot
);

    logic               r_active;
    logic [BURST_W-1:0] r_rem;
    logic [BURST_W-1:0] r_burst;
    logic [TIME_W-1:0]  r_arr;
    logic [SEQ_W-1:0]   r_seq;

    t_scan              r_rec;
    t_scan              n_rec;
    logic [SW-1:0]      r_best_slot;
    logic [SW-1:0]      n_best_slot;

    logic               w_load;
    logic               w_act;
    logic               w_take;
    logic               w_is_last;
    logic               w_hit;
    logic [BURST_W-1:0] w_rem;
    logic [BURST_W-1:0] w_burst;
    logic [TIME_W-1:0]  w_age;
    logic [SEQ_W-1:0]   w_seq;

    // slot view as seen by this tick, new arrival included
    always_comb begin
        w_load  = i_rec.valid && i_rec.arrive && !r_active;
        w_act   = r_active || w_load;
        w_rem   = w_load ? i_rec.burst : r_rem;
        w_burst = w_load ? i_rec.burst : r_burst;
        w_seq   = w_load ? i_rec.seq   : r_seq;
        w_age   = w_load ? '0 : i_ctl.now - r_arr;
    end

    // least remaining wins, equal remaining goes to the older task
    always_comb begin
        w_take = i_rec.valid && w_act &&
                 (!i_rec.best_ok || (w_rem < i_rec.best_rem) ||
                  ((w_rem == i_rec.best_rem) && (w_age > i_rec.best_age)));
        w_is_last = i_rec.valid && r_active && i_ctl.last_valid &&
                    (i_last_slot == SW'(IDX));
        w_hit = i_ctl.commit && (i_pick_slot == SW'(IDX));
    end

    // fold this slot into the record
    always_comb begin
        n_rec       = i_rec;
        n_best_slot = i_best_slot;
        if (w_load) begin
            n_rec.arrive = 1'b0;
            n_rec.placed = 1'b1;
        end
        if (w_take) begin
            n_rec.best_ok    = 1'b1;
            n_rec.best_rem   = w_rem;
            n_rec.best_age   = w_age;
            n_rec.best_seq   = w_seq;
            n_rec.best_burst = w_burst;
            n_best_slot      = SW'(IDX);
        end
        if (w_is_last) begin
            n_rec.last_ok    = 1'b1;
            n_rec.last_rem   = r_rem;
            n_rec.last_age   = w_age;
            n_rec.last_seq   = r_seq;
            n_rec.last_burst = r_burst;
        end
    end

    // record stage to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.valid <= 1'b0;
        end else begin
            r_rec       <= n_rec;
            r_best_slot <= n_best_slot;
        end
    end

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_load) begin
            r_active <= 1'b1;
        end else if (w_hit && i_ctl.finish) begin
            r_active <= 1'b0;
        end
    end

    // slot payload: load on arrival, count down when picked
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem   <= i_rec.burst;
            r_burst <= i_rec.burst;
            r_arr   <= i_ctl.now;
            r_seq   <= i_rec.seq;
        end else if (w_hit) begin
            r_rem <= r_rem - BURST_W'(1);
        end
    end

    assign o_rec       = r_rec;
    assign o_best_slot = r_best_slot;

endmodule

FILE: src/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl - tick sequencer
// Launches the scan record, settles the pick at the end of the row, commits
// the run to the chosen cell and keeps time, numbering and the result item.
// ----------------------------------------------------------------------------
`include "srtf_task_scheduler_top_macros.svh"

module srtf_ctrl import srtf_pkg::*; #(
    parameter  int TASK_SLOTS = TASK_SLOTS_DEF,
    localparam int SW         = $clog2(TASK_SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    srtf_tick_if.sink            i_tick,
    srtf_result_if.source        o_result,
    output t_scan                o_rec,
    input  t_scan                i_rec,
    input  logic [SW-1:0]        i_best_slot,
    output t_ctl                 o_ctl,
    output logic [SW-1:0]        o_last_slot,
    output logic [SW-1:0]        o_pick_slot
);

    t_state            r_state;
    t_state            n_state;
    logic [TIME_W-1:0] r_time;
    logic [SEQ_W-1:0]  r_next;
    logic              r_last_valid;
    logic [SW-1:0]     r_last_slot;
    logic              r_pick_valid;
    logic [SW-1:0]     r_pick_slot;
    logic              r_finish;
    logic              r_placed;
    t_result           r_res;
    t_result           n_res;
    logic              r_out_valid;
    t_result           r_out;

    logic               w_accept;
    logic               w_fire;
    logic               w_end;
    logic               w_use_last;
    logic               w_finish;
    logic [BURST_W-1:0] w_sel_rem;
    logic [TIME_W-1:0]  w_sel_age;
    logic [SEQ_W-1:0]   w_sel_seq;
    logic [BURST_W-1:0] w_sel_burst;
    logic [SW-1:0]      w_sel_slot;
    logic [TIME_W-1:0]  w_ta;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_tick.valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_rec.valid) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!r_out_valid || o_result.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_tick.ready = (r_state == ST_IDLE);
        w_accept     = (r_state == ST_IDLE) && i_tick.valid;
        w_end        = (r_state == ST_SCAN) && i_rec.valid;
        w_fire       = (r_state == ST_COMMIT) && (!r_out_valid || o_result.ready);
    end

    // record launched into the first cell
    always_comb begin
        o_rec        = '0;
        o_rec.valid  = w_accept;
        o_rec.arrive = i_tick.arrive_valid && (i_tick.burst != '0);
        o_rec.burst  = i_tick.burst;
        o_rec.seq    = r_next;
    end

    // broadcast to the cells
    always_comb begin
        o_ctl.now        = r_time;
        o_ctl.last_valid = r_last_valid;
        o_ctl.commit     = w_fire && r_pick_valid;
        o_ctl.finish     = r_finish;
        o_last_slot      = r_last_slot;
        o_pick_slot      = r_pick_slot;
    end

    // final pick: the task that ran last keeps the slot on a tie
    always_comb begin
        w_use_last  = i_rec.last_ok && (i_rec.last_rem == i_rec.best_rem);
        w_sel_rem   = w_use_last ? i_rec.last_rem   : i_rec.best_rem;
        w_sel_age   = w_use_last ? i_rec.last_age   : i_rec.best_age;
        w_sel_seq   = w_use_last ? i_rec.last_seq   : i_rec.best_seq;
        w_sel_burst = w_use_last ? i_rec.last_burst : i_rec.best_burst;
        w_sel_slot  = w_use_last ? r_last_slot      : i_best_slot;
        w_finish    = i_rec.best_ok && (w_sel_rem == BURST_W'(1));
        w_ta        = w_sel_age + TIME_W'(1);
    end

    // result of this tick
    always_comb begin
        n_res             = '0;
        n_res.ran_valid   = i_rec.best_ok;
        n_res.dropped     = i_rec.arrive;
        if (i_rec.best_ok) begin
            n_res.task_number = w_sel_seq;
        end
        if (w_finish) begin
            n_res.finished        = 1'b1;
            n_res.completion_time = r_time + TIME_W'(1);
            n_res.turnaround      = w_ta;
            n_res.waiting         = w_ta - TIME_W'(w_sel_burst);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pick capture at the end of the row
    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_res        <= n_res;
            r_pick_slot  <= w_sel_slot;
            r_finish     <= w_finish;
            r_placed     <= i_rec.placed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_valid <= 1'b0;
        end else if (w_end) begin
            r_pick_valid <= i_rec.best_ok;
        end
    end

    // time, numbering and last-run slot advance when the tick commits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_next       <= SEQ_W'(1);
            r_last_valid <= 1'b0;
        end else if (w_fire) begin
            r_time <= r_time + TIME_W'(1);
            if (r_placed) begin
                r_next <= r_next + SEQ_W'(1);
            end
            if (r_pick_valid) begin
                r_last_valid <= !r_finish;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_pick_valid) begin
            r_last_slot <= r_pick_slot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= r_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.ran_valid       = r_out.ran_valid;
    assign o_result.task_number     = r_out.task_number;
    assign o_result.finished        = r_out.finished;
    assign o_result.completion_time = r_out.completion_time;
    assign o_result.turnaround      = r_out.turnaround;
    assign o_result.waiting         = r_out.waiting;
    assign o_result.dropped         = r_out.dropped;

    // checks
    `SRTF_ASSERT_IMP(a_rec_in_scan, i_clk, i_rst_n, i_rec.valid, r_state == ST_SCAN, "record left the row outside a scan")
    `SRTF_ASSERT_NXT(a_accept_scan, i_clk, i_rst_n, w_accept, r_state == ST_SCAN, "accepted item did not start a scan")
    `SRTF_ASSERT_IMP(a_last_has_best, i_clk, i_rst_n, i_rec.valid && i_rec.last_ok, i_rec.best_ok, "last-run task seen but no best task")
    `SRTF_ASSERT_NXT(a_finish_clears_last, i_clk, i_rst_n, o_ctl.commit && o_ctl.finish, !r_last_valid, "finished task still marked as last run")
    `SRTF_ASSERT_IMP(a_finish_ran, i_clk, i_rst_n, r_out_valid && r_out.finished, r_out.ran_valid, "finished flag without a run")

endmodule

FILE: src/srtf_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// srtf_task_scheduler_top - shortest-remaining-time-first scheduler
// Row of task-slot cells walked by a scan record, driven by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick carries one scheduler tick per item, optionally with a new task
//   (arrive_valid, burst). o_result returns exactly one item per tick: the
//   task that ran, its completion data when it finished, and a drop flag
//   when no slot was free for the arrival.
//   Each tick walks a record through the TASK_SLOTS cells, one cell per
//   cycle; the sequencer then settles the pick, commits the run and
//   registers the result. No new tick is accepted until the previous one
//   has committed. The length of the cell row sets how long a tick takes.
//   Reset clears all slots, the tick counter and the last-run mark; task
//   numbering restarts at one.
//   The result sits in an output register; a new tick is taken while it
//   waits, and a stalled receiver holds the following tick at its commit
//   step until the register frees up.
// ----------------------------------------------------------------------------
module srtf_task_scheduler_top import srtf_pkg::*; #(
    parameter  int TASK_SLOTS = TASK_SLOTS_DEF,
    localparam int SW         = $clog2(TASK_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srtf_tick_if.sink     i_tick,
    srtf_result_if.source o_result
);

    t_scan         w_rec  [TASK_SLOTS+1];
    logic [SW-1:0] w_slot [TASK_SLOTS+1];
    t_ctl          w_ctl;
    logic [SW-1:0] w_last_slot;
    logic [SW-1:0] w_pick_slot;

    assign w_slot[0] = '0;

    // sequencer
    srtf_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick),
        .o_result    (o_result),
        .o_rec       (w_rec[0]),
        .i_rec       (w_rec[TASK_SLOTS]),
        .i_best_slot (w_slot[TASK_SLOTS]),
        .o_ctl       (w_ctl),
        .o_last_slot (w_last_slot),
        .o_pick_slot (w_pick_slot)
    );

    // row of task slots
    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        srtf_cell #(
            .TASK_SLOTS (TASK_SLOTS),
            .IDX        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_last_slot (w_last_slot),
            .i_pick_slot (w_pick_slot),
            .i_rec       (w_rec[g]),
            .i_best_slot (w_slot[g]),
            .o_rec       (w_rec[g+1]),
            .o_best_slot (w_slot[g+1])
        );
    end

endmodule

FILE: tb/srtf_schedule_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srtf_schedule_check - scheduler result checker
// Watches the tick and result channels and runs its own shortest-remaining-
// time-first schedule for every accepted tick. It compares each result item
// field by field with the oldest prediction and reports failures and
// coverage counts to the testbench top.
// ----------------------------------------------------------------------------
module srtf_schedule_check import srtf_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    srtf_tick_if   i_tick,
    srtf_result_if i_result,
    output int     o_failures,
    output int     o_pending,
    output int     o_completions,
    output int     o_drops,
    output int     o_idle_ticks
);

    // per-slot task records, read only while the slot is busy
    logic [BURST_W-1:0]    slot_left  [TASK_SLOTS];
    logic [BURST_W-1:0]    slot_burst [TASK_SLOTS];
    logic [TIME_W-1:0]     slot_born  [TASK_SLOTS];
    logic [SEQ_W-1:0]      slot_id    [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] slot_busy;

    logic                  prev_ok;
    int                    prev_slot;
    logic [TIME_W-1:0]     tick_now;
    logic [SEQ_W-1:0]      next_id;

    t_result               due_results [$];
    t_result               want_r;
    t_result               got_r;

    // one scheduler tick: place the arrival, pick a task, run one unit
    function automatic t_result run_one_tick(input logic arrive,
                                             input logic [BURST_W-1:0] burst);
        t_result           r;
        int                pick;
        logic              placed;
        logic [TIME_W-1:0] age_i;
        logic [TIME_W-1:0] age_p;
        logic [TIME_W-1:0] done;
        r      = '0;
        placed = 1'b0;

        // lowest free slot takes the arrival, zero burst is ignored
        if (arrive && burst != '0) begin
            for (int i = 0; i < TASK_SLOTS && !placed; i++) begin
                if (!slot_busy[i]) begin
                    slot_left[i]  = burst;
                    slot_burst[i] = burst;
                    slot_born[i]  = tick_now;
                    slot_id[i]    = next_id;
                    slot_busy[i]  = 1'b1;
                    next_id       = next_id + 1'b1;
                    placed        = 1'b1;
                end
            end
            if (!placed)
                r.dropped = 1'b1;
        end

        // least remaining time, equal times go to the oldest arrival
        pick = -1;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (slot_busy[i]) begin
                if (pick < 0) begin
                    pick = i;
                end else if (slot_left[i] < slot_left[pick]) begin
                    pick = i;
                end else if (slot_left[i] == slot_left[pick]) begin
                    age_i = tick_now - slot_born[i];
                    age_p = tick_now - slot_born[pick];
                    if (age_i > age_p)
                        pick = i;
                end
            end
        end

        // a tie with the task that ran last keeps it running
        if (pick >= 0 && prev_ok && slot_busy[prev_slot] &&
            slot_left[prev_slot] == slot_left[pick])
            pick = prev_slot;

        if (pick >= 0) begin
            r.ran_valid       = 1'b1;
            r.task_number     = slot_id[pick];
            slot_left[pick]   = slot_left[pick] - 1'b1;
            prev_ok           = 1'b1;
            prev_slot         = pick;
            if (slot_left[pick] == '0) begin
                done              = tick_now + 1'b1;
                r.finished        = 1'b1;
                r.completion_time = done;
                r.turnaround      = done - slot_born[pick];
                r.waiting         = r.turnaround - TIME_W'(slot_burst[pick]);
                slot_busy[pick]   = 1'b0;
                prev_ok           = 1'b0;
            end
        end

        tick_now = tick_now + 1'b1;
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_failures++;
        end
    endfunction

    // compare result items first, then predict for the tick item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_busy     = '0;
            prev_ok       = 1'b0;
            prev_slot     = 0;
            tick_now      = '0;
            next_id       = SEQ_W'(1);
            due_results.delete();
            o_failures    = 0;
            o_pending     = 0;
            o_completions = 0;
            o_drops       = 0;
            o_idle_ticks  = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (due_results.size() == 0) begin
                    $error("result item with no tick waiting for it");
                    o_failures++;
                end else begin
                    want_r = due_results.pop_front();
                    check_field("ran_valid", want_r.ran_valid, i_result.ran_valid);
                    check_field("task_number", want_r.task_number, i_result.task_number);
                    check_field("finished", want_r.finished, i_result.finished);
                    check_field("completion_time", want_r.completion_time,
                                i_result.completion_time);
                    check_field("turnaround", want_r.turnaround, i_result.turnaround);
                    check_field("waiting", want_r.waiting, i_result.waiting);
                    check_field("dropped", want_r.dropped, i_result.dropped);
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                got_r = run_one_tick(i_tick.arrive_valid, i_tick.burst);
                o_completions += got_r.finished;
                o_drops       += got_r.dropped;
                o_idle_ticks  += !got_r.ran_valid;
                due_results.push_back(got_r);
            end
            o_pending = due_results.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - scheduler top-level test
// Drives scheduler ticks with and without task arrivals: a directed opening
// for idle ticks, ignored arrivals, ties, preemption and a full slot table,
// then random load phases. Both channels pause at random; the checker
// predicts every result and the verdict follows its failure count.
// ----------------------------------------------------------------------------
module testbench;
    import srtf_pkg::*;

    localparam int TASK_SLOTS   = TASK_SLOTS_DEF;
    localparam int RANDOM_TICKS = 925;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 2 * (TASK_SLOTS + 2);
    localparam int ARRIVE_PCT [4] = '{0, 30, 60, 95};

    typedef enum int {
        PACE_FULL,
        PACE_LOOSE,
        PACE_TIGHT
    } t_pace;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;

    int    failures;
    int    pending;
    int    completions;
    int    drops;
    int    idle_ticks;
    int    ticks_sent    = 0;
    int    arrivals_sent = 0;
    int    quiet_cycles  = 0;
    t_pace send_pace     = PACE_LOOSE;

    srtf_tick_if   tick_ch ();
    srtf_result_if result_ch ();

    srtf_task_scheduler_top #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch)
    );

    srtf_schedule_check #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_schedule_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick_ch),
        .i_result      (result_ch),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_completions (completions),
        .o_drops       (drops),
        .o_idle_ticks  (idle_ticks)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int draw_wait(input t_pace pace);
        case (pace)
            PACE_FULL:  return 0;
            PACE_LOOSE: return $urandom_range(0, 15);
            default:    return $urandom_range(0, 3);
        endcase
    endfunction

    // one tick item, valid stays up when there is no gap before it
    task automatic send_tick(input logic arrive, input logic [BURST_W-1:0] burst);
        int gap;
        gap = draw_wait(send_pace);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.arrive_valid <= arrive;
        tick_ch.burst        <= burst;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
        ticks_sent++;
        if (arrive)
            arrivals_sent++;
    endtask

    // stall watchdog: no item moved on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles", IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result receiver with random stalls in phases
    initial begin
        int    stall;
        int    phase_left;
        t_pace take_pace;
        result_ch.ready = 1'b0;
        phase_left      = 0;
        take_pace       = PACE_FULL;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 50);
                take_pace  = t_pace'($urandom_range(0, 2));
            end
            phase_left--;
            stall = draw_wait(take_pace);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            @(negedge i_clk);
        end
    end

    // reset, directed ticks, random load phases, drain and verdict
    initial begin
        int                 counted;
        int                 seg_left;
        int                 arrive_pct;
        int                 pick;
        logic               arrive;
        logic [BURST_W-1:0] burst;
        tick_ch.valid        = 1'b0;
        tick_ch.arrive_valid = 1'b0;
        tick_ch.burst        = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle tick with all burst bits set, then a zero-burst arrival
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'h0000);
        // shortest task finishes at once
        send_tick(1'b1, 16'h0001);
        // tie kept by the running task, then tie to the older arrival
        send_tick(1'b1, 16'h0002);
        send_tick(1'b1, 16'h0001);
        send_tick(1'b1, 16'h0001);
        send_tick(1'b0, 16'h5A5A);
        // longest task, then a short one preempts it
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b1, 16'h0005);
        // fill every slot, the last arrival finds none free
        repeat (16) send_tick(1'b1, 16'd16);

        // random load phases: arrival rate and pacing change per phase
        counted  = 0;
        seg_left = 0;
        arrive_pct = 0;
        while (counted < RANDOM_TICKS) begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(10, 60);
                arrive_pct = ARRIVE_PCT[$urandom_range(0, 3)];
                send_pace  = t_pace'($urandom_range(0, 2));
            end
            seg_left--;
            arrive = ($urandom_range(0, 99) < arrive_pct);
            pick   = $urandom_range(0, 199);
            // mostly short bursts so tasks complete, a rare long one
            if (!arrive)
                burst = BURST_W'($urandom);
            else if (pick == 0)
                burst = BURST_W'($urandom_range(1, 65535));
            else if (pick < 4)
                burst = '0;
            else if (pick < 40)
                burst = BURST_W'($urandom_range(1, 40));
            else
                burst = BURST_W'($urandom_range(1, 8));
            send_tick(arrive, burst);
            if (!(arrive && burst == '0))
                counted++;
        end
        tick_ch.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("ran %0d ticks with %0d arrivals", ticks_sent, arrivals_sent);
        $display("saw %0d completions, %0d drops, %0d idle ticks",
                 completions, drops, idle_ticks);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
